[hdl/gsc_pkg.sv]
// Shared types and constants of the grid segment cost check.
// Used by the controller, the datapath, the divider and the top level; no dependencies.
package gsc_pkg;

  // Coordinate width (Q12.8 meters) and the shared divider width
  localparam int unsigned CoordW = 20;
  localparam int unsigned DivW   = 21;
  localparam int unsigned RootW  = 21;

  // Configuration register indexes
  localparam logic [2:0] CFG_STEP   = 3'd0;
  localparam logic [2:0] CFG_CPM_X  = 3'd1;
  localparam logic [2:0] CFG_CPM_Y  = 3'd2;
  localparam logic [2:0] CFG_THRESH = 3'd3;
  localparam logic [2:0] CFG_WIDTH  = 3'd4;
  localparam logic [2:0] CFG_HEIGHT = 3'd5;

  // Input item kinds
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic [15:0] step;
    logic [15:0] cpm_x;
    logic [15:0] cpm_y;
    logic [7:0]  thresh;
    logic [8:0]  width;
    logic [8:0]  height;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic cap;        // capture query points
    logic wr;         // write one grid cell
    logic sq;         // square the deltas
    logic sinit;      // load root iteration
    logic sstep;      // one root iteration
    logic dstart_n;   // divide distance by step
    logic dcap_n;     // capture step count
    logic dstart_x;   // divide |dx| by n
    logic dcap_x;
    logic dstart_y;   // divide |dy| by n
    logic dcap_y;
    logic walk_init;
    logic pt;         // next walk point to cell coordinates
    logic idx;        // cell change check and address
    logic rd;         // grid read
    logic acc;        // add cost, check threshold
    logic oload;      // load result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sqrt_last;
    logic div_done;
    logic n_zero;
    logic same;
    logic last;
    logic hit;
  } stat_t;

  // round(cost * 256 / 255) equals cost plus one when cost >= 128
  function automatic logic [8:0] cost_term(input logic [7:0] c);
    cost_term = {1'b0, c} + {8'd0, c[7]};
  endfunction

endpackage

[hdl/gsc_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Depends on gsc_pkg for the operand width.
module gsc_div
  import gsc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [DivW-1:0] divisor_i,
  output logic            done_o,
  output logic [DivW-1:0] quo_o,
  output logic [DivW-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(DivW);

  logic [DivW-1:0] quo_q, quo_d, rem_q, rem_d, dvs_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DivW:0]   shifted;

  // Operand load on start, else trial subtract of the shifted partial remainder
  always_comb begin
    shifted = {rem_q, quo_q[DivW-1]};
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = DivW'(shifted - {1'b0, dvs_q});
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = shifted[DivW-1:0];
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

[hdl/gsc_datapath.sv]
// Datapath: grid memory, distance root, shared divider use and segment walk.
// Depends on gsc_pkg and gsc_div.
module gsc_datapath
  import gsc_pkg::*;
#(
  parameter int unsigned GRID_CELLS = 65536,
  parameter int unsigned MAX_STEPS  = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  input  cfg_t              cfg_i,
  input  logic [15:0]       cell_index_i,
  input  logic [7:0]        cell_cost_i,
  input  logic [CoordW-1:0] sample_x_i,
  input  logic [CoordW-1:0] sample_y_i,
  input  logic [CoordW-1:0] anchor_x_i,
  input  logic [CoordW-1:0] anchor_y_i,
  output logic [31:0]       total_cost_o,
  output logic              blocked_o
);

  localparam int unsigned AW = $clog2(GRID_CELLS);
  localparam int unsigned NW = $clog2(MAX_STEPS + 1);
  localparam logic [DivW-1:0] MaxN  = DivW'(MAX_STEPS);
  localparam logic [DivW-1:0] Cells = DivW'(GRID_CELLS);

  // Grid memory
  logic [7:0]    grid_mem [GRID_CELLS];
  logic [DivW-1:0] wr_ext;
  assign wr_ext = {5'd0, cell_index_i};

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && (wr_ext < Cells)) begin
      grid_mem[wr_ext[AW-1:0]] <= cell_cost_i;
    end
  end

  // Query capture
  logic [CoordW-1:0] ax_q, ay_q, mx_q, my_q;
  logic              negx_q, negy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      ax_q   <= anchor_x_i;
      ay_q   <= anchor_y_i;
      negx_q <= sample_x_i < anchor_x_i;
      negy_q <= sample_y_i < anchor_y_i;
      mx_q   <= (sample_x_i < anchor_x_i) ? anchor_x_i - sample_x_i
                                          : sample_x_i - anchor_x_i;
      my_q   <= (sample_y_i < anchor_y_i) ? anchor_y_i - sample_y_i
                                          : sample_y_i - anchor_y_i;
    end
  end

  // Squares, then a digit-by-digit root, two radicand bits a cycle
  logic [2*CoordW-1:0] mxx_q, myy_q;
  logic [41:0]         sval_q;
  logic [21:0]         srem_q;
  logic [RootW-1:0]    root_q;
  logic [4:0]          scnt_q;
  logic [23:0]         srem_sh, strial;

  assign srem_sh = {srem_q, sval_q[41:40]};
  assign strial  = {1'b0, root_q, 2'b01};

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq) begin
      mxx_q <= mx_q * mx_q;
      myy_q <= my_q * my_q;
    end
    if (cmd_i.sinit) begin
      sval_q <= {1'b0, {1'b0, mxx_q} + {1'b0, myy_q}};
      srem_q <= '0;
      root_q <= '0;
      scnt_q <= '0;
    end else if (cmd_i.sstep) begin
      sval_q <= {sval_q[39:0], 2'b00};
      scnt_q <= scnt_q + 5'd1;
      if (srem_sh >= strial) begin
        srem_q <= 22'(srem_sh - strial);
        root_q <= {root_q[RootW-2:0], 1'b1};
      end else begin
        srem_q <= srem_sh[21:0];
        root_q <= {root_q[RootW-2:0], 1'b0};
      end
    end
  end

  // Shared divider
  logic            div_start, div_done;
  logic [DivW-1:0] div_a, div_b, div_quo, div_rem;
  logic [NW-1:0]   n_q;

  assign div_start = cmd_i.dstart_n | cmd_i.dstart_x | cmd_i.dstart_y;

  always_comb begin
    priority if (cmd_i.dstart_n) begin
      div_a = root_q;
      div_b = {5'd0, cfg_i.step};
    end else if (cmd_i.dstart_x) begin
      div_a = {1'b0, mx_q};
      div_b = DivW'(n_q);
    end else begin
      div_a = {1'b0, my_q};
      div_b = DivW'(n_q);
    end
  end

  gsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // Step count and walk increments (offset j = q*j + carries of r*j over n)
  logic [CoordW-1:0] qx_q, qy_q, offx_q, offy_q;
  logic [NW-1:0]     rx_q, ry_q, remx_q, remy_q, j_q;
  logic [NW:0]       sumx, sumy;
  logic              cyx, cyy;

  assign sumx = {1'b0, remx_q} + {1'b0, rx_q};
  assign sumy = {1'b0, remy_q} + {1'b0, ry_q};
  assign cyx  = sumx >= {1'b0, n_q};
  assign cyy  = sumy >= {1'b0, n_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.dcap_n) begin
      if (cfg_i.step == 16'd0) begin
        n_q <= '0;
      end else if (div_quo > MaxN) begin
        n_q <= NW'(MAX_STEPS);
      end else begin
        n_q <= div_quo[NW-1:0];
      end
    end
    if (cmd_i.dcap_x) begin
      qx_q <= div_quo[CoordW-1:0];
      rx_q <= div_rem[NW-1:0];
    end
    if (cmd_i.dcap_y) begin
      qy_q <= div_quo[CoordW-1:0];
      ry_q <= div_rem[NW-1:0];
    end
    if (cmd_i.walk_init) begin
      offx_q <= '0;
      offy_q <= '0;
      remx_q <= '0;
      remy_q <= '0;
      j_q    <= '0;
    end else if (cmd_i.pt) begin
      offx_q <= offx_q + qx_q + CoordW'(cyx);
      offy_q <= offy_q + qy_q + CoordW'(cyy);
      remx_q <= cyx ? NW'(sumx - {1'b0, n_q}) : sumx[NW-1:0];
      remy_q <= cyy ? NW'(sumy - {1'b0, n_q}) : sumy[NW-1:0];
      j_q    <= j_q + NW'(1);
    end
  end

  // Point to cell coordinates
  logic [CoordW-1:0]    px, py, cx_q, cy_q, pcx_q, pcy_q;
  logic [CoordW+15:0]   prodx, prody;
  logic                 last_q, have_prev_q;

  assign px    = negx_q ? ax_q - offx_q : ax_q + offx_q;
  assign py    = negy_q ? ay_q - offy_q : ay_q + offy_q;
  assign prodx = px * cfg_i.cpm_x;
  assign prody = py * cfg_i.cpm_y;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pt) begin
      cx_q   <= prodx[CoordW+15:16];
      cy_q   <= prody[CoordW+15:16];
      last_q <= (j_q == n_q - NW'(1));
    end
  end

  // Cell change check and linear address
  logic            out_map;
  logic [17:0]     lin;
  logic [DivW-1:0] lin_ext;
  logic [AW-1:0]   addr_q;
  logic            oob_q;

  assign out_map = (cx_q >= CoordW'(cfg_i.width)) || (cy_q >= CoordW'(cfg_i.height));
  assign lin     = ({9'd0, cy_q[8:0]} * {9'd0, cfg_i.width}) + {9'd0, cx_q[8:0]};
  assign lin_ext = {3'd0, lin};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
    end else if (cmd_i.walk_init) begin
      have_prev_q <= 1'b0;
    end else if (cmd_i.idx) begin
      have_prev_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.idx) begin
      pcx_q  <= cx_q;
      pcy_q  <= cy_q;
      addr_q <= lin_ext[AW-1:0];
      oob_q  <= out_map || (lin_ext >= Cells);
    end
  end

  // Grid read, registered
  logic [7:0] rd_q, cost;
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_q <= grid_mem[addr_q];
    end
  end

  assign cost = oob_q ? 8'd255 : rd_q;

  // Running total, blocked flag and result registers
  logic [31:0] total_q, res_total_q;
  logic        blocked_q, res_blocked_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      blocked_q <= 1'b0;
    end else if (cmd_i.acc && (cost >= cfg_i.thresh)) begin
      blocked_q <= 1'b1;
    end
    // 10*D as 8*D + 2*D
    if (cmd_i.dstart_n) begin
      total_q <= {8'd0, root_q, 3'd0} + {10'd0, root_q, 1'b0};
    end else if (cmd_i.acc) begin
      total_q <= total_q + {23'd0, cost_term(cost)};
    end
    if (cmd_i.oload) begin
      res_total_q   <= total_q;
      res_blocked_q <= blocked_q;
    end
  end

  assign total_cost_o = res_total_q;
  assign blocked_o    = res_blocked_q;

  assign stat_o.sqrt_last = (scnt_q == 5'd20);
  assign stat_o.div_done  = div_done;
  assign stat_o.n_zero    = (n_q == '0);
  assign stat_o.same      = have_prev_q && (cx_q == pcx_q) && (cy_q == pcy_q);
  assign stat_o.last      = last_q;
  assign stat_o.hit       = (cost >= cfg_i.thresh);

endmodule

[hdl/gsc_ctrl.sv]
// Controller state machine: handshakes and sequencing of the datapath.
// Depends on gsc_pkg for the command and status structs.
module gsc_ctrl
  import gsc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  logic  func_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_SQ    = 15'b000000000000010,
    S_SINIT = 15'b000000000000100,
    S_SQRT  = 15'b000000000001000,
    S_DN    = 15'b000000000010000,
    S_DNW   = 15'b000000000100000,
    S_DX    = 15'b000000001000000,
    S_DXW   = 15'b000000010000000,
    S_DY    = 15'b000000100000000,
    S_DYW   = 15'b000001000000000,
    S_PT    = 15'b000010000000000,
    S_IDX   = 15'b000100000000000,
    S_RD    = 15'b001000000000000,
    S_ACC   = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_xfer, slot_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (func_i == FUNC_QUERY) begin
            cmd_o.cap = 1'b1;
            state_d   = S_SQ;
          end else begin
            cmd_o.wr = 1'b1;
          end
        end
      end
      S_SQ: begin
        cmd_o.sq = 1'b1;
        state_d  = S_SINIT;
      end
      S_SINIT: begin
        cmd_o.sinit = 1'b1;
        state_d     = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sstep = 1'b1;
        if (stat_i.sqrt_last) begin
          state_d = S_DN;
        end
      end
      S_DN: begin
        cmd_o.dstart_n = 1'b1;
        state_d        = S_DNW;
      end
      S_DNW: begin
        if (stat_i.div_done) begin
          cmd_o.dcap_n = 1'b1;
          state_d      = S_DX;
        end
      end
      S_DX: begin
        if (stat_i.n_zero) begin
          state_d = S_OUT;
        end else begin
          cmd_o.dstart_x  = 1'b1;
          cmd_o.walk_init = 1'b1;
          state_d         = S_DXW;
        end
      end
      S_DXW: begin
        if (stat_i.div_done) begin
          cmd_o.dcap_x = 1'b1;
          state_d      = S_DY;
        end
      end
      S_DY: begin
        cmd_o.dstart_y = 1'b1;
        state_d        = S_DYW;
      end
      S_DYW: begin
        if (stat_i.div_done) begin
          cmd_o.dcap_y = 1'b1;
          state_d      = S_PT;
        end
      end
      S_PT: begin
        cmd_o.pt = 1'b1;
        state_d  = S_IDX;
      end
      S_IDX: begin
        cmd_o.idx = 1'b1;
        priority if (!stat_i.same) begin
          state_d = S_RD;
        end else if (stat_i.last) begin
          state_d = S_OUT;
        end else begin
          state_d = S_PT;
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        priority if (stat_i.hit || stat_i.last) begin
          state_d = S_OUT;
        end else begin
          state_d = S_PT;
        end
      end
      S_OUT: begin
        if (slot_free) begin
          cmd_o.oload = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.oload) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A loaded result is shown in the next cycle
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && slot_free) |=> out_valid_q)
    else $error("result load not visible");

  // Divider completion only while waiting for it
  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.div_done |-> (state_q == S_DNW || state_q == S_DXW || state_q == S_DYW))
    else $error("divider done outside a wait state");

  // A blocking cell ends the walk
  a_hit_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC && stat_i.hit) |=> (state_q == S_OUT))
    else $error("walk continued past a blocking cell");

endmodule

[hdl/grid_segment_cost_check.sv]
// Grid segment cost check, top level: configuration registers and the
// controller and datapath. A query runs a setup (squares, 21-step root,
// three divisions), walks its points, reads and adds each newly entered
// cell, then loads the result; with no point walked the setup ends after
// the first division. One query at a time; the next item is taken the
// cycle after the result loads. A cell write is taken in the idle state.
// Reset is asynchronous, active low, and restores the register defaults;
// the grid holds no defined contents until written.
module grid_segment_cost_check
  import gsc_pkg::*;
#(
  parameter int unsigned GRID_CELLS = 65536,
  parameter int unsigned MAX_STEPS  = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [15:0] cell_index_i,
  input  logic [7:0]  cell_cost_i,
  input  logic [19:0] sample_x_i,
  input  logic [19:0] sample_y_i,
  input  logic [19:0] anchor_x_i,
  input  logic [19:0] anchor_y_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] total_cost_o,
  output logic        blocked_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t  cfg_q;
  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step   <= 16'd26;
      cfg_q.cpm_x  <= 16'd5120;
      cfg_q.cpm_y  <= 16'd5120;
      cfg_q.thresh <= 8'd253;
      cfg_q.width  <= 9'd256;
      cfg_q.height <= 9'd256;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_STEP:   cfg_q.step   <= cfg_data_i;
        CFG_CPM_X:  cfg_q.cpm_x  <= cfg_data_i;
        CFG_CPM_Y:  cfg_q.cpm_y  <= cfg_data_i;
        CFG_THRESH: cfg_q.thresh <= cfg_data_i[7:0];
        CFG_WIDTH:  cfg_q.width  <= cfg_data_i[8:0];
        CFG_HEIGHT: cfg_q.height <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  gsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  gsc_datapath #(
    .GRID_CELLS (GRID_CELLS),
    .MAX_STEPS  (MAX_STEPS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_i        (cfg_q),
    .cell_index_i (cell_index_i),
    .cell_cost_i  (cell_cost_i),
    .sample_x_i   (sample_x_i),
    .sample_y_i   (sample_y_i),
    .anchor_x_i   (anchor_x_i),
    .anchor_y_i   (anchor_y_i),
    .total_cost_o (total_cost_o),
    .blocked_o    (blocked_o)
  );

endmodule
